// ----- src/kmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmsd_pkg: shared types and constants for the keypad scanner
// Event codes, the no-key marker and the result record passed between
// the debounce core and the top level.
// ----------------------------------------------------------------------------
package kmsd_pkg;

	localparam int unsigned KEY_W    = 4;
	localparam int unsigned KEYS     = 16;
	localparam int unsigned CAND_W   = 5;
	localparam int unsigned COUNT_W  = 8;

	localparam logic [CAND_W-1:0]  NO_KEY        = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
	localparam logic [COUNT_W-1:0] THRESHOLD_RST = 8'd10;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} event_t;

	typedef struct packed {
		event_t           ev;
		logic [KEY_W-1:0] key;
	} result_t;

endpackage

// ----- src/kmsd_scan_if.sv -----
// ----------------------------------------------------------------------------
// kmsd_scan_if: scan sample channel
// Valid/ready channel that carries one 16-bit key matrix sample.
// ----------------------------------------------------------------------------
interface kmsd_scan_if;
	logic        valid;
	logic        ready;
	logic [15:0] key_matrix;

	modport source (output valid, output key_matrix, input ready);
	modport sink (input valid, input key_matrix, output ready);
endinterface

// ----- src/kmsd_result_if.sv -----
// ----------------------------------------------------------------------------
// kmsd_result_if: key event channel
// Valid/ready channel that carries one key event and its key index.
// ----------------------------------------------------------------------------
interface kmsd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [3:0] key_index;

	modport source (output valid, output event_res, output key_index, input ready);
	modport sink (input valid, input event_res, input key_index, output ready);
endinterface

// ----- src/kmsd_debounce.sv -----
// ----------------------------------------------------------------------------
// kmsd_debounce: priority encoder and debounce state
// Picks the first pressed key of a sample and updates the candidate key,
// confidence count and held flag when step is high.
// ----------------------------------------------------------------------------
module kmsd_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [15:0]                   key_matrix,
	input  logic [kmsd_pkg::COUNT_W-1:0]  threshold,
	output kmsd_pkg::result_t             res
);

	logic                          held_q;
	logic [kmsd_pkg::COUNT_W-1:0]  count_q;
	logic [kmsd_pkg::CAND_W-1:0]   cand_q;

	logic                          held_d;
	logic [kmsd_pkg::COUNT_W-1:0]  count_d;
	logic [kmsd_pkg::CAND_W-1:0]   cand_d;
	logic [kmsd_pkg::COUNT_W-1:0]  count_inc;
	logic [kmsd_pkg::CAND_W-1:0]   scanned;

	// lowest set bit wins: column 0 first, row 0 first
	always_comb begin
		scanned = kmsd_pkg::NO_KEY;
		for (int i = kmsd_pkg::KEYS - 1; i >= 0; i--) begin
			if (key_matrix[i]) begin
				scanned = kmsd_pkg::CAND_W'(i);
			end
		end
	end

	assign count_inc = (count_q == kmsd_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		held_d  = held_q;
		count_d = count_q;
		cand_d  = cand_q;
		res.ev  = kmsd_pkg::EV_NONE;
		res.key = '0;
		if (scanned == cand_q) begin
			if (scanned != kmsd_pkg::NO_KEY) begin
				if (!held_q) begin
					count_d = count_inc;
					if (count_inc >= threshold) begin
						held_d  = 1'b1;
						res.ev  = kmsd_pkg::EV_PRESS;
						res.key = cand_q[kmsd_pkg::KEY_W-1:0];
					end
				end else begin
					count_d = threshold;
				end
			end
		end else if (held_q) begin
			if (count_q <= 8'd1) begin
				count_d = '0;
				held_d  = 1'b0;
				cand_d  = scanned;
				res.ev  = kmsd_pkg::EV_RELEASE;
			end else begin
				count_d = count_q - 1'b1;
			end
		end else begin
			count_d = '0;
			cand_d  = scanned;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			count_q <= '0;
			cand_q  <= kmsd_pkg::NO_KEY;
		end else if (step) begin
			held_q  <= held_d;
			count_q <= count_d;
			cand_q  <= cand_d;
		end
	end

	a_held_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> cand_q != kmsd_pkg::NO_KEY)
		else $error("held flag set without a candidate key");

	a_press_sets_held: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.ev == kmsd_pkg::EV_PRESS |=> held_q)
		else $error("press event did not set held");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.ev == kmsd_pkg::EV_RELEASE |=> !held_q && count_q == '0)
		else $error("release event did not clear state");

	a_press_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.ev == kmsd_pkg::EV_PRESS |-> !held_q && res.key == cand_q[kmsd_pkg::KEY_W-1:0])
		else $error("press event while already held or wrong key");

endmodule

// ----- src/keypad_matrix_scan_debounce.sv -----
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce: 4x4 key matrix scanner with debounce
// Takes key matrix samples, reports debounced press and release events.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : sink channel, one 16-bit sample per request, bit col*4+row set
//            when that key reads pressed.
//   result : source channel, exactly one event per sample (none, press with
//            key index, or release), in sample order.
//   wr_en / wr_data : debounce threshold write; change it only while idle.
// Path: an accepted sample is registered in the input register and moves
//   into the result register once that register is free to take it.
// Throughput: one sample per cycle while results are taken; the encode
//   and debounce update form combinational logic between the two registers.
// Reset: threshold returns to 10, no key held, count zero, both stages empty.
// Stall: while result is not taken the result register holds, the input
//   register holds behind it, and scan.ready drops once both are full.
// ----------------------------------------------------------------------------
module keypad_matrix_scan_debounce (
	input  logic                  clk,
	input  logic                  arst_n,
	kmsd_scan_if.sink             scan,
	kmsd_result_if.source         result,
	input  logic                  wr_en,
	input  logic [7:0]            wr_data
);

	logic                          valid_s1;
	logic [15:0]                   matrix_s1;
	logic                          out_valid_q;
	kmsd_pkg::result_t             res_q;
	kmsd_pkg::result_t             res_d;
	logic [kmsd_pkg::COUNT_W-1:0]  threshold_q;
	logic                          out_free;
	logic                          advance;

	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign scan.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= kmsd_pkg::THRESHOLD_RST;
		end else if (wr_en) begin
			threshold_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			matrix_s1 <= scan.key_matrix;
		end
	end

	kmsd_debounce u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.key_matrix (matrix_s1),
		.threshold  (threshold_q),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.event_res = res_q.ev;
	assign result.key_index = res_q.key;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> valid_s1 && out_valid_q)
		else $error("input stalled with a free stage");

	a_release_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ev != kmsd_pkg::EV_PRESS |-> res_q.key == '0)
		else $error("key index set on a non-press event");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost on advance");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x4 keypad scanner with debounce
// Feeds key matrix samples through the scan channel and checks each key event.
// A short table covers the matrix extremes, thresholds of zero, one and 255,
// release from a zero count and a lowered threshold. Random phases follow with
// press and release runs, bounces and noise, and checks every event against a
// local debounce predictor. Each phase sets an idle and a stall percentage.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT = 2000;

	typedef enum logic {ROW_SCAN, ROW_THR} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [15:0]        val;
		bit                 typed;
		kmsd_pkg::result_t  want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [7:0] wr_data;

	kmsd_scan_if   scan_ch ();
	kmsd_result_if event_ch ();

	keypad_matrix_scan_debounce dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan_ch),
		.result  (event_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	// debounce predictor state
	logic [kmsd_pkg::COUNT_W-1:0] model_thr   = kmsd_pkg::THRESHOLD_RST;
	logic                         model_held  = 1'b0;
	logic [kmsd_pkg::COUNT_W-1:0] model_count = '0;
	logic [kmsd_pkg::CAND_W-1:0]  model_cand  = kmsd_pkg::NO_KEY;

	kmsd_pkg::result_t pending_events [$];
	kmsd_pkg::result_t next_event;
	int      fail_count   = 0;
	int      quiet_cycles = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;

	dir_row_t directed_rows [0:24] = '{
		'{ROW_THR,  16'h0001, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0000, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0001, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0001, 1'b1, '{kmsd_pkg::EV_PRESS,   4'd0}},
		'{ROW_SCAN, 16'hFFFF, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0000, 1'b1, '{kmsd_pkg::EV_RELEASE, 4'd0}},
		'{ROW_SCAN, 16'h8000, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h8000, 1'b1, '{kmsd_pkg::EV_PRESS,   4'd15}},
		'{ROW_SCAN, 16'h8000, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_THR,  16'h0000, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h8000, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		// held key with zero count releases on the first mismatch
		'{ROW_SCAN, 16'h0010, 1'b1, '{kmsd_pkg::EV_RELEASE, 4'd0}},
		'{ROW_SCAN, 16'h0010, 1'b1, '{kmsd_pkg::EV_PRESS,   4'd4}},
		'{ROW_SCAN, 16'hF0F0, 1'b1, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_THR,  16'h00FF, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0100, 1'b1, '{kmsd_pkg::EV_RELEASE, 4'd0}},
		'{ROW_SCAN, 16'h0100, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0300, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0F00, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		// drop the threshold under the running count
		'{ROW_THR,  16'h0002, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0100, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h000C, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h7FFE, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0000, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}},
		'{ROW_SCAN, 16'h0000, 1'b0, '{kmsd_pkg::EV_NONE,    4'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic kmsd_pkg::result_t predict_key_event(input logic [15:0] m);
		logic [kmsd_pkg::CAND_W-1:0] seen;
		kmsd_pkg::result_t           r;
		int                          i;
		seen  = kmsd_pkg::NO_KEY;
		r.ev  = kmsd_pkg::EV_NONE;
		r.key = '0;
		for (i = 15; i >= 0; i--)
			if (m[i])
				seen = kmsd_pkg::CAND_W'(i);
		if (seen == model_cand) begin
			if (seen != kmsd_pkg::NO_KEY) begin
				if (!model_held) begin
					if (model_count != kmsd_pkg::COUNT_MAX)
						model_count++;
					if (model_count >= model_thr) begin
						model_held = 1'b1;
						r.ev       = kmsd_pkg::EV_PRESS;
						r.key      = model_cand[kmsd_pkg::KEY_W-1:0];
					end
				end else begin
					model_count = model_thr;
				end
			end
		end else if (model_held) begin
			if (model_count <= 1) begin
				model_count = '0;
				model_held  = 1'b0;
				model_cand  = seen;
				r.ev        = kmsd_pkg::EV_RELEASE;
			end else begin
				model_count--;
			end
		end else begin
			model_count = '0;
			model_cand  = seen;
		end
		return r;
	endfunction

	// lowest set bit is the key, bits above it random, 16 gives an empty matrix
	function automatic logic [15:0] matrix_for(input int k);
		logic [15:0] upper;
		upper = 16'($urandom);
		if (k >= kmsd_pkg::KEYS)
			return 16'h0000;
		return (upper & (16'hFFFF << k)) | (16'h0001 << k);
	endfunction

	// enter and leave at a falling edge; valid stays high on return
	task automatic send_scan(input logic [15:0] m, input bit typed = 1'b0,
			input kmsd_pkg::result_t want = '0);
		kmsd_pkg::result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			scan_ch.valid <= 1'b0;
			@(negedge clk);
		end
		scan_ch.valid      <= 1'b1;
		scan_ch.key_matrix <= m;
		do
			@(posedge clk);
		while (!scan_ch.ready);
		predicted = predict_key_event(m);
		pending_events.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] v);
		scan_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en     <= 1'b0;
		model_thr  = v;
	endtask

	task automatic scan_stream(input int n);
		int sent;
		int pick;
		int k;
		int other;
		int len;
		int j;
		int glitch_at;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 9);
			k    = $urandom_range(0, 15);
			if (pick < 7) begin
				// hold one key past the threshold, maybe with a single bounce
				len       = model_thr + 1 + $urandom_range(0, 3);
				glitch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
				for (j = 0; j < len; j++) begin
					if (j == glitch_at) begin
						other = $urandom_range(0, 16);
						send_scan(matrix_for(other));
						sent++;
					end
					send_scan(matrix_for(k));
					sent++;
				end
				// let go, now and then bouncing back or rolling to another key
				len = model_thr + $urandom_range(0, 2);
				for (j = 0; j < len; j++) begin
					if (j > 0 && $urandom_range(0, 7) == 0)
						other = k;
					else if ($urandom_range(0, 3) == 0)
						other = $urandom_range(0, 16);
					else
						other = kmsd_pkg::KEYS;
					send_scan(matrix_for(other));
					sent++;
				end
			end else if (pick == 7) begin
				len = $urandom_range(2, 6);
				for (j = 0; j < len; j++) begin
					send_scan(matrix_for($urandom_range(0, 16)));
					sent++;
				end
			end else begin
				len = $urandom_range(1, 4);
				for (j = 0; j < len; j++) begin
					send_scan(16'($urandom));
					sent++;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		event_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && event_ch.valid && event_ch.ready) begin
			if (pending_events.size() == 0) begin
				$error("event_res: no event expected, actual %0d key_index %0d",
					event_ch.event_res, event_ch.key_index);
				fail_count++;
			end else begin
				next_event = pending_events.pop_front();
				if (event_ch.event_res !== next_event.ev) begin
					$error("event_res: expected %0d, actual %0d",
						next_event.ev, event_ch.event_res);
					fail_count++;
				end
				if (event_ch.key_index !== next_event.key) begin
					$error("key_index: expected %0d, actual %0d",
						next_event.key, event_ch.key_index);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((scan_ch.valid && scan_ch.ready) || (event_ch.valid && event_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int phase_thr   [6];
		int phase_idle  [6];
		int phase_stall [6];
		int phase_items [6];
		int p;
		int r;
		phase_thr   = '{3, 1, 40, 0, -1, 10};
		phase_idle  = '{0, 76, 0, 0, 27, 0};
		phase_stall = '{0, 0, 76, 76, 27, 0};
		phase_items = '{100, 80, 240, 60, 100, 60};

		scan_ch.valid      = 1'b0;
		scan_ch.key_matrix = 16'h0000;
		event_ch.ready     = 1'b0;
		wr_en              = 1'b0;
		wr_data            = 8'h00;
		arst_n             = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].kind == ROW_THR)
				write_threshold(directed_rows[r].val[7:0]);
			else
				send_scan(directed_rows[r].val, directed_rows[r].typed,
					directed_rows[r].want);
		end

		for (p = 0; p < 6; p++) begin
			send_idle_pct  = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			if (phase_thr[p] < 0)
				write_threshold(8'($urandom_range(2, 20)));
			else
				write_threshold(8'(phase_thr[p]));
			scan_stream(phase_items[p]);
		end

		scan_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending_events.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/kmsd_pkg.sv
src/kmsd_scan_if.sv
src/kmsd_result_if.sv
src/kmsd_debounce.sv
src/keypad_matrix_scan_debounce.sv
tb/sv/tb_top.sv
